// ===== sv/gls_pkg.sv =====
// Shared constants, register indexes and state type for the grid line-of-sight block.
package gls_pkg;

    localparam int COORD_W      = 6;   // tile coordinate field width
    localparam int CFG_W        = 7;   // width of map_width / map_height
    localparam int CFG_IDX_W    = 1;   // two configuration registers
    localparam int MAP_SIDE_DEF = 64;  // default store side
    localparam int IN_TDATA_W   = 32;  // 25 payload bits, padded to bytes
    localparam int OUT_TDATA_W  = 8;   // 1 payload bit, padded to a byte

    localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/grid_line_of_sight.sv =====
// Top level: wall-bit map with a one-tile-per-cycle Bresenham line-of-sight walker.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: command; tdata: start_x, start_y,
//                                                target_x, target_y, wall_bit
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: visible
//  cfg       in   cfg_wr_en (no back-pressure)   cfg_index, cfg_wr_data
//
//  After reset the block sweeps the wall store to zero, one tile per cycle, over all
//  MAP_SIDE*MAP_SIDE tiles (4096 at the default side); s_axis_tready stays low meanwhile.
//  A write beat is stored, if its tile is in the store, as it is taken. A query beat
//  is walked in ST_WALK and its verdict loaded in ST_FINISH: the single step unit
//  (error add/compare plus next-tile address) and the one read port of the store
//  handle one tile per cycle. The verdict then sits in the output register, so a new
//  beat is taken while it waits; only a second verdict waits on m_axis_tready.
module grid_line_of_sight #(
    parameter int MAP_SIDE = gls_pkg::MAP_SIDE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [5:0] start_x, [11:6] start_y, [17:12] target_x, [23:18] target_y, [24] wall_bit
    input  logic [gls_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] visible
    output logic [gls_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,

    input  logic                             cfg_wr_en,
    input  logic [gls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gls_pkg::CFG_W-1:0]        cfg_wr_data
);

    localparam int CW     = gls_pkg::COORD_W;
    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = ADDR_W + CW;
    localparam int SIDE_W = $clog2(MAP_SIDE + 1);
    localparam int DIM_W  = (gls_pkg::CFG_W > SIDE_W) ? gls_pkg::CFG_W : SIDE_W;
    localparam int ERR_W  = CW + 3;  // |err| <= dx + dy, with margin

    // tile inside the physical store
    function automatic logic in_store(input logic [CW-1:0] col, input logic [CW-1:0] row);
        in_store = (PROD_W'(col) < PROD_W'(MAP_SIDE)) && (PROD_W'(row) < PROD_W'(MAP_SIDE));
    endfunction

    // row-major store address, zero for tiles beyond the store
    function automatic logic [ADDR_W-1:0] tile_addr(input logic [CW-1:0] col,
                                                    input logic [CW-1:0] row);
        logic [PROD_W-1:0] lin;
        lin = PROD_W'(row) * PROD_W'(MAP_SIDE) + PROD_W'(col);
        tile_addr = in_store(col, row) ? lin[ADDR_W-1:0] : '0;
    endfunction

    // input beat fields
    logic [CW-1:0] in_sx, in_sy, in_tx, in_ty;
    logic          in_wall;
    assign in_sx   = s_axis_tdata[CW-1:0];
    assign in_sy   = s_axis_tdata[2*CW-1:CW];
    assign in_tx   = s_axis_tdata[3*CW-1:2*CW];
    assign in_ty   = s_axis_tdata[4*CW-1:3*CW];
    assign in_wall = s_axis_tdata[4*CW];

    // configuration
    logic [gls_pkg::CFG_W-1:0] map_width_reg, map_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= gls_pkg::DIM_RESET;
            map_height_reg <= gls_pkg::DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gls_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg_wr_data;
                gls_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // bounds in use, clamped to the store side
    logic [DIM_W-1:0] width_eff, height_eff;
    assign width_eff  = (DIM_W'(map_width_reg) > DIM_W'(MAP_SIDE)) ?
                        DIM_W'(MAP_SIDE) : DIM_W'(map_width_reg);
    assign height_eff = (DIM_W'(map_height_reg) > DIM_W'(MAP_SIDE)) ?
                        DIM_W'(MAP_SIDE) : DIM_W'(map_height_reg);

    // walker state
    gls_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]          x_reg, x_next, y_reg, y_next;
    logic [CW-1:0]          tx_reg, tx_next, ty_reg, ty_next;
    logic [CW-1:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic                   xpos_reg, xpos_next, ypos_reg, ypos_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                   result_reg, result_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_visible_reg, m_visible_next;

    // wall store ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic              mem_wdata;
    logic              rd_wall_reg;
    logic              wall_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wall_mem[mem_waddr] <= mem_wdata;
        end
        rd_wall_reg <= wall_mem[mem_raddr];
    end

    // step unit: bounds, target and Bresenham error update for the current tile
    logic                    out_of_bounds, at_target, step_x, step_y;
    logic signed [ERR_W:0]   e2, dx_w, dy_w;
    logic signed [ERR_W-1:0] dx_e, dy_e, err_step;
    logic [CW-1:0]           x_step, y_step, in_dx, in_dy;

    assign out_of_bounds = (DIM_W'(x_reg) >= width_eff) || (DIM_W'(y_reg) >= height_eff);
    assign at_target     = (x_reg == tx_reg) && (y_reg == ty_reg);
    assign e2            = {err_reg, 1'b0};
    assign dx_w          = $signed((ERR_W+1)'(dx_reg));
    assign dy_w          = $signed((ERR_W+1)'(dy_reg));
    assign dx_e          = $signed(ERR_W'(dx_reg));
    assign dy_e          = $signed(ERR_W'(dy_reg));
    assign step_x        = e2 > -dy_w;
    assign step_y        = e2 < dx_w;
    assign err_step      = err_reg - (step_x ? dy_e : ERR_W'(0)) + (step_y ? dx_e : ERR_W'(0));
    assign x_step        = step_x ? (xpos_reg ? x_reg + 1'b1 : x_reg - 1'b1) : x_reg;
    assign y_step        = step_y ? (ypos_reg ? y_reg + 1'b1 : y_reg - 1'b1) : y_reg;
    assign in_dx         = (in_tx > in_sx) ? in_tx - in_sx : in_sx - in_tx;
    assign in_dy         = (in_ty > in_sy) ? in_ty - in_sy : in_sy - in_ty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gls_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        tx_reg        <= tx_next;
        ty_reg        <= ty_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        xpos_reg      <= xpos_next;
        ypos_reg      <= ypos_next;
        err_reg       <= err_next;
        result_reg    <= result_next;
        m_visible_reg <= m_visible_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        xpos_next      = xpos_reg;
        ypos_next      = ypos_reg;
        err_next       = err_reg;
        result_next    = result_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_visible_next = m_visible_reg;
        s_axis_tready  = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = tile_addr(in_sx, in_sy);
        mem_wdata      = in_wall;
        mem_raddr      = tile_addr(x_step, y_step);  // prefetch the next tile's wall bit

        case (state_reg)
            gls_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = gls_pkg::ST_IDLE;
                end
            end

            gls_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mem_raddr     = tile_addr(in_sx, in_sy);
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == gls_pkg::CMD_WRITE)
                    begin
                        mem_we = in_store(in_sx, in_sy);
                    end
                    else
                    begin
                        x_next     = in_sx;
                        y_next     = in_sy;
                        tx_next    = in_tx;
                        ty_next    = in_ty;
                        dx_next    = in_dx;
                        dy_next    = in_dy;
                        xpos_next  = in_sx < in_tx;
                        ypos_next  = in_sy < in_ty;
                        err_next   = $signed(ERR_W'(in_dx)) - $signed(ERR_W'(in_dy));
                        state_next = gls_pkg::ST_WALK;
                    end
                end
            end

            gls_pkg::ST_WALK:
            begin
                // bounds first, then target (its wall bit ignored), then wall
                if (out_of_bounds)
                begin
                    result_next = 1'b0;
                    state_next  = gls_pkg::ST_FINISH;
                end
                else if (at_target)
                begin
                    result_next = 1'b1;
                    state_next  = gls_pkg::ST_FINISH;
                end
                else if (rd_wall_reg)
                begin
                    result_next = 1'b0;
                    state_next  = gls_pkg::ST_FINISH;
                end
                else
                begin
                    x_next   = x_step;
                    y_next   = y_step;
                    err_next = err_step;
                end
            end

            gls_pkg::ST_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_visible_next = result_reg;
                    state_next     = gls_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gls_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(gls_pkg::OUT_TDATA_W-1){1'b0}}, m_visible_reg};

endmodule

// ===== bench/testbench.sv =====
// Testbench for grid_line_of_sight: directed table plus random write/query traffic.
module testbench;

    localparam int SIDE      = gls_pkg::MAP_SIDE_DEF;
    localparam int CW        = gls_pkg::COORD_W;
    localparam int DIM_W     = gls_pkg::CFG_W;
    localparam int HOLD_LONG = 600;    // long receiver hold-off, in cycles
    localparam int SETTLE    = 8;      // idle cycles before a register write

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic                          cmd;
        logic [gls_pkg::COORD_W-1:0]   sx;
        logic [gls_pkg::COORD_W-1:0]   sy;
        logic [gls_pkg::COORD_W-1:0]   tx;
        logic [gls_pkg::COORD_W-1:0]   ty;
        logic                          wb;
        logic [gls_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [gls_pkg::CFG_W-1:0]     reg_val;
        bit                            typed;    // verdict typed in the row
        bit                            verdict;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [gls_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [gls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                              cfg_wr_en;
    logic [gls_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [gls_pkg::CFG_W-1:0]         cfg_wr_data;

    // Shadow state of the block
    bit                                wall_bits [0:SIDE*SIDE-1];
    logic [gls_pkg::CFG_W-1:0]         cols_in_use;
    logic [gls_pkg::CFG_W-1:0]         rows_in_use;

    bit                       verdict_q [$];   // visible bits still owed by the block
    stim_row_t                plan_q [$];
    int                       mismatches;
    bit                       calm;            // no idling on either side
    bit                       hold_req;        // ask the receiver for a long hold-off

    grid_line_of_sight dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Bresenham walk over the shadow map; a dimension above the store side acts as the side.
    function automatic bit line_clear(int x, int y, int tx, int ty);
        int w;
        int h;
        int dx;
        int dy;
        int step_x;
        int step_y;
        int err;
        int e2;
        w      = (cols_in_use > SIDE) ? SIDE : int'(cols_in_use);
        h      = (rows_in_use > SIDE) ? SIDE : int'(rows_in_use);
        dx     = (tx > x) ? tx - x : x - tx;
        dy     = (ty > y) ? ty - y : y - ty;
        step_x = (x < tx) ? 1 : -1;
        step_y = (y < ty) ? 1 : -1;
        err    = dx - dy;
        for (int guard = 0; guard < 4*SIDE; guard++)
        begin
            if (x < 0 || x >= w || y < 0 || y >= h)
                return 1'b0;
            if (x == tx && y == ty)
                return 1'b1;          // target's own wall bit is not looked at
            if (wall_bits[y*SIDE + x])
                return 1'b0;
            e2 = 2*err;
            if (e2 > -dy)
            begin
                err -= dy;
                x   += step_x;
            end
            if (e2 < dx)
            begin
                err += dx;
                y   += step_y;
            end
        end
        return 1'b0;
    endfunction

    function automatic stim_row_t beat_row(logic cmd, int sx, int sy, int tx, int ty,
                                           logic wb);
        stim_row_t r;
        r = '{kind: ROW_BEAT, cmd: cmd, sx: CW'(sx), sy: CW'(sy), tx: CW'(tx), ty: CW'(ty),
              wb: wb, reg_idx: '0, reg_val: '0, typed: 1'b0, verdict: 1'b0};
        return r;
    endfunction

    // Query row whose verdict is obvious from the map and the bounds
    function automatic stim_row_t seen_row(int sx, int sy, int tx, int ty, logic wb,
                                           bit vis);
        stim_row_t r;
        r         = beat_row(gls_pkg::CMD_QUERY, sx, sy, tx, ty, wb);
        r.typed   = 1'b1;
        r.verdict = vis;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [gls_pkg::CFG_IDX_W-1:0] idx, int val);
        stim_row_t r;
        r         = beat_row(gls_pkg::CMD_WRITE, 0, 0, 0, 0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = DIM_W'(val);
        return r;
    endfunction

    // Offer one beat from a falling edge; return at the falling edge after it is taken.
    task automatic push_beat(stim_row_t r);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {7'd0, r.wb, r.ty, r.tx, r.sy, r.sx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (r.cmd == gls_pkg::CMD_WRITE)
            wall_bits[int'(r.sy)*SIDE + int'(r.sx)] = r.wb;  // bounds registers ignored
        else if (r.typed)
            verdict_q.push_back(r.verdict);
        else
            verdict_q.push_back(line_clear(int'(r.sx), int'(r.sy), int'(r.tx), int'(r.ty)));
        @(negedge clk);
    endtask

    // Stop offering, let every owed verdict arrive, then give a trailing write time to land.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [gls_pkg::CFG_IDX_W-1:0] idx,
                             logic [gls_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        if (idx == gls_pkg::REG_MAP_WIDTH)
            cols_in_use = val;
        else
            rows_in_use = val;
    endtask

    // Random beat: mostly a 16x16 corner so walls get dense and walks stay short.
    function automatic stim_row_t random_row();
        stim_row_t r;
        int        span;
        logic      cmd;
        span = ($urandom_range(0, 9) < 7) ? 15 : SIDE-1;
        cmd  = $urandom_range(0, 1) ? gls_pkg::CMD_QUERY : gls_pkg::CMD_WRITE;
        r    = beat_row(cmd, int'($urandom_range(0, span)), int'($urandom_range(0, span)),
                        int'($urandom_range(0, span)), int'($urandom_range(0, span)),
                        1'($urandom_range(0, 1)));
        if (cmd == gls_pkg::CMD_WRITE)
        begin
            r.wb = ($urandom_range(0, 9) < 6);
            r.tx = CW'($urandom_range(0, SIDE-1));   // ignored on a write, still toggled
            r.ty = CW'($urandom_range(0, SIDE-1));
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            r.tx = r.sx;
            r.ty = r.sy;
        end
        return r;
    endfunction

    // Receiver: short random stalls, one long hold-off on request, none when calm.
    initial
    begin
        int hold_len;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                hold_len = HOLD_LONG;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                hold_len = $urandom_range(1, 5);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold_len = 1;
            end
            repeat (hold_len) @(negedge clk);
        end
    end

    // Verdict checker: every output beat against the oldest owed verdict.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("visible: expected none, actual %0d", m_axis_tdata[0]);
                mismatches++;
            end
            else if (m_axis_tdata[0] !== verdict_q[0])
            begin
                $error("visible: expected %0d, actual %0d", verdict_q[0], m_axis_tdata[0]);
                mismatches++;
                void'(verdict_q.pop_front());
            end
            else
                void'(verdict_q.pop_front());
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial
    begin
        int phase_w [8] = '{64, 127, 16, 0, 64, 1, -1, 64};
        int phase_h [8] = '{64, 127, 16, 64, 0, 1, -1, 64};
        int phase_n [8] = '{200, 150, 200, 40, 40, 40, 150, 200};
        int w;
        int h;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gls_pkg::CMD_WRITE;
        cfg_wr_en     = 1'b0;
        cfg_index     = gls_pkg::REG_MAP_WIDTH;
        cfg_wr_data   = '0;
        mismatches    = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        cols_in_use   = gls_pkg::DIM_RESET;
        rows_in_use   = gls_pkg::DIM_RESET;
        foreach (wall_bits[i])
            wall_bits[i] = 1'b0;

        // Directed table; the first beat waits out the clearing sweep.
        plan_q.push_back(seen_row(0, 0, 63, 63, 1'b0, 1'b1));     // empty map after reset
        plan_q.push_back(seen_row(63, 0, 0, 63, 1'b1, 1'b1));     // wall_bit ignored on query
        plan_q.push_back(beat_row(gls_pkg::CMD_WRITE, 63, 63, 63, 63, 1'b1));
        plan_q.push_back(seen_row(0, 0, 63, 63, 1'b0, 1'b1));     // walled target still seen
        plan_q.push_back(seen_row(63, 63, 0, 0, 1'b0, 1'b0));     // start on a wall
        plan_q.push_back(beat_row(gls_pkg::CMD_WRITE, 10, 10, 0, 0, 1'b1));
        plan_q.push_back(seen_row(10, 10, 10, 10, 1'b0, 1'b1));   // start is target, wall or not
        plan_q.push_back(seen_row(10, 10, 20, 10, 1'b0, 1'b0));
        plan_q.push_back(seen_row(0, 10, 20, 10, 1'b0, 1'b0));    // wall mid-row
        plan_q.push_back(seen_row(10, 0, 10, 63, 1'b0, 1'b0));    // wall mid-column
        plan_q.push_back(beat_row(gls_pkg::CMD_QUERY, 3, 7, 40, 22, 1'b0));
        plan_q.push_back(beat_row(gls_pkg::CMD_WRITE, 10, 10, 0, 0, 1'b0));
        plan_q.push_back(seen_row(0, 10, 20, 10, 1'b0, 1'b1));
        plan_q.push_back(beat_row(gls_pkg::CMD_WRITE, 63, 63, 0, 0, 1'b0));
        plan_q.push_back(reg_row(gls_pkg::REG_MAP_WIDTH, 0));
        plan_q.push_back(seen_row(5, 5, 5, 5, 1'b0, 1'b0));       // zero width: nothing in bounds
        plan_q.push_back(reg_row(gls_pkg::REG_MAP_WIDTH, 127));
        plan_q.push_back(seen_row(0, 0, 63, 63, 1'b0, 1'b1));     // oversized width acts as 64
        plan_q.push_back(reg_row(gls_pkg::REG_MAP_HEIGHT, 1));
        plan_q.push_back(seen_row(0, 0, 63, 0, 1'b0, 1'b1));
        plan_q.push_back(seen_row(3, 2, 3, 2, 1'b0, 1'b0));       // start out of bounds
        plan_q.push_back(seen_row(0, 0, 5, 1, 1'b0, 1'b0));       // walk leaves the rows in use
        plan_q.push_back(reg_row(gls_pkg::REG_MAP_WIDTH, 1));
        plan_q.push_back(reg_row(gls_pkg::REG_MAP_HEIGHT, 127));
        plan_q.push_back(seen_row(0, 63, 0, 0, 1'b0, 1'b1));
        plan_q.push_back(seen_row(1, 0, 1, 0, 1'b0, 1'b0));
        plan_q.push_back(beat_row(gls_pkg::CMD_QUERY, 0, 5, 40, 9, 1'b1));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == ROW_REG)
            begin
                settle();
                write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
            end
            else
                push_beat(plan_q[i]);
        end

        // Random phases, each under its own map size. The first starts with a long
        // output hold-off so the block backs up; the last runs without idling.
        for (int p = 0; p < 8; p++)
        begin
            settle();
            w = (phase_w[p] < 0) ? $urandom_range(1, 64) : phase_w[p];
            h = (phase_h[p] < 0) ? $urandom_range(1, 64) : phase_h[p];
            write_reg(gls_pkg::REG_MAP_WIDTH, DIM_W'(w));
            write_reg(gls_pkg::REG_MAP_HEIGHT, DIM_W'(h));
            if (p == 0)
                hold_req = 1'b1;
            if (p == 7)
                calm = 1'b1;
            repeat (phase_n[p])
                push_beat(random_row());
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/gls_pkg.sv
sv/grid_line_of_sight.sv
bench/testbench.sv
